FILE: sv/i2d_pkg.sv
// Shared widths, character codes and a digit helper for the decimal text converter.
package i2d_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumDig  = 10;
  localparam int unsigned BcdW    = 4 * NumDig;
  localparam int unsigned CharW   = 7;
  localparam int unsigned LenW    = 4;
  localparam int unsigned DigW    = $clog2(NumDig + 1);
  localparam int unsigned StepW   = $clog2(WordW);

  localparam logic [CharW-1:0] AsciiZero  = 7'h30;
  localparam logic [CharW-1:0] AsciiMinus = 7'h2D;
  localparam logic [LenW-1:0]  MaxLen     = 4'd11;

  typedef logic [BcdW-1:0] bcd_t;

  // Add three to a BCD digit of five or more, ahead of the shift.
  function automatic logic [3:0] dig_adjust(input logic [3:0] dig);
    dig_adjust = (dig >= 4'd5) ? dig + 4'd3 : dig;
  endfunction

endpackage

FILE: sv/i2d_in_if.sv
// Input channel: one binary word and its signedness flag.
interface i2d_in_if;
  logic                        valid;
  logic                        ready;
  logic [i2d_pkg::WordW-1:0]   value;
  logic                        is_signed;

  modport source (output valid, value, is_signed, input ready);
  modport sink   (input valid, value, is_signed, output ready);
endinterface

FILE: sv/i2d_out_if.sv
// Output channel: one ASCII character with end marker and text length.
interface i2d_out_if;
  logic                        valid;
  logic                        ready;
  logic [i2d_pkg::CharW-1:0]   out_char;
  logic                        last;
  logic [i2d_pkg::LenW-1:0]    length;

  modport source (output valid, out_char, last, length, input ready);
  modport sink   (input valid, out_char, last, length, output ready);
endinterface

FILE: sv/i2d_bcd_step.sv
// Shared shift-add-3 unit: one double-dabble step over all BCD digits.
module i2d_bcd_step (
  input  i2d_pkg::bcd_t bcd_i,
  input  logic          bit_i,
  output i2d_pkg::bcd_t bcd_o
);
  import i2d_pkg::*;

  bcd_t adj;

  always_comb begin
    for (int d = 0; d < NumDig; d++) begin
      adj[4*d +: 4] = dig_adjust(bcd_i[4*d +: 4]);
    end
  end

  assign bcd_o = {adj[BcdW-2:0], bit_i};

endmodule

FILE: sv/int_to_decimal_ascii_top.sv
// Top level: binary word to minimal decimal ASCII text, one character per item.
//
//   channel  dir  payload                      handshake
//   in_i     in   value[31:0], is_signed       valid/ready
//   out_o    out  out_char[6:0], last, length  valid/ready
//
// An item passes through an accept state, one shift-add-3 step per input bit
// in the shared unit, leading-zero trimming down to at least one digit, and
// character emission, with a minus sign first for a negative signed value.
// Input ready is high only while the sequencer is idle; output stalls hold
// the character register and pause emission. Reset clears control state only.
module int_to_decimal_ascii_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2d_in_if.sink        in_i,
  i2d_out_if.source     out_o
);
  import i2d_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StTrim = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]       st_q, st_d;
  logic [WordW-1:0] bin_q, bin_d;
  bcd_t             bcd_q, bcd_d;
  bcd_t             bcd_step;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [DigW-1:0]  ndig_q, ndig_d;
  logic             neg_q, neg_d;
  logic [LenW-1:0]  total_q, total_d;

  logic             ov_q, ov_d;
  logic [CharW-1:0] och_q, och_d;
  logic             olast_q, olast_d;
  logic [LenW-1:0]  olen_q, olen_d;

  logic             in_acc;
  logic             neg_in;
  logic             load;

  i2d_bcd_step u_step (
    .bcd_i (bcd_q),
    .bit_i (bin_q[WordW-1]),
    .bcd_o (bcd_step)
  );

  assign in_i.ready = (st_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign neg_in     = in_i.is_signed && in_i.value[WordW-1];
  assign load       = (st_q == StEmit) && (!ov_q || out_o.ready);

  always_comb begin
    st_d    = st_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    ndig_d  = ndig_q;
    neg_d   = neg_q;
    total_d = total_q;
    ov_d    = ov_q && !out_o.ready;
    och_d   = och_q;
    olast_d = olast_q;
    olen_d  = olen_q;
    unique case (st_q)
      StIdle: begin
        if (in_acc) begin
          neg_d  = neg_in;
          bin_d  = neg_in ? (~in_i.value + WordW'(1)) : in_i.value;
          bcd_d  = '0;
          cnt_d  = '0;
          st_d   = StConv;
        end
      end
      StConv: begin
        bcd_d = bcd_step;
        bin_d = {bin_q[WordW-2:0], 1'b0};
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(WordW - 1)) begin
          ndig_d = DigW'(NumDig);
          st_d   = StTrim;
        end
      end
      StTrim: begin
        if (bcd_q[BcdW-1 -: 4] == 4'd0 && ndig_q > DigW'(1)) begin
          bcd_d  = {bcd_q[BcdW-5:0], 4'd0};
          ndig_d = ndig_q - DigW'(1);
        end else begin
          total_d = LenW'(ndig_q) + LenW'(neg_q);
          st_d    = StEmit;
        end
      end
      StEmit: begin
        if (load) begin
          ov_d = 1'b1;
          if (neg_q) begin
            och_d   = AsciiMinus;
            olast_d = 1'b0;
            olen_d  = '0;
            neg_d   = 1'b0;
          end else begin
            och_d   = AsciiZero + CharW'(bcd_q[BcdW-1 -: 4]);
            olast_d = (ndig_q == DigW'(1));
            olen_d  = (ndig_q == DigW'(1)) ? total_q : '0;
            bcd_d   = {bcd_q[BcdW-5:0], 4'd0};
            ndig_d  = ndig_q - DigW'(1);
            if (ndig_q == DigW'(1)) begin
              st_d = StIdle;
            end
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    bcd_q   <= bcd_d;
    cnt_q   <= cnt_d;
    ndig_q  <= ndig_d;
    neg_q   <= neg_d;
    total_q <= total_d;
    och_q   <= och_d;
    olast_q <= olast_d;
    olen_q  <= olen_d;
  end

  assign out_o.valid    = ov_q;
  assign out_o.out_char = och_q;
  assign out_o.last     = olast_q;
  assign out_o.length   = olen_q;

  a_acc_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (st_q == StConv))
    else $error("accepted item did not start conversion");

  a_len_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && olast_q) |-> (olen_q != '0 && olen_q <= MaxLen))
    else $error("bad length on last character");

  a_len_zero_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !olast_q) |-> (olen_q == '0 && (och_q == AsciiMinus || och_q >= AsciiZero)))
    else $error("length set on inner character");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && och_q != AsciiMinus) |->
      (och_q >= AsciiZero && och_q <= AsciiZero + CharW'(9)))
    else $error("character is not a decimal digit");

endmodule

FILE: dv/int_to_decimal_ascii_top_tb.sv
`timescale 1ns / 1ps
// Testbench for int_to_decimal_ascii_top: directed table, then random words checked by a predictor.
module int_to_decimal_ascii_top_tb;
  import i2d_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             last;
    logic [LenW-1:0]  length;
  } text_char_t;

  typedef struct {
    logic [WordW-1:0] value;
    logic             is_signed;
    string            text;
  } stim_row_t;

  localparam int unsigned NumRows    = 18;
  localparam int unsigned NumRandom  = 200;
  localparam int unsigned HoldCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni;

  i2d_in_if  in_ch ();
  i2d_out_if out_ch ();

  int_to_decimal_ascii_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #2 clk_i = ~clk_i;

  text_char_t  pending_chars[$];
  text_char_t  want_char;
  stim_row_t   directed_rows[NumRows];
  int          errors       = 0;
  int          snd_idle_pct = 25;
  int          rcv_idle_pct = 73;
  int          idle_phase   = 0;
  bit          hold_done    = 1'b0;

  function automatic void push_text(input string text);
    text_char_t c;
    for (int i = 0; i < text.len(); i++) begin
      c.out_char = CharW'(text[i]);
      c.last     = (i == text.len() - 1);
      c.length   = c.last ? LenW'(text.len()) : '0;
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void predict_text(input logic [WordW-1:0] word, input logic sgn);
    logic             neg;
    logic [WordW-1:0] mag;
    logic [3:0]       digits[NumDig];
    int               ndig;
    int               total;
    text_char_t       c;
    neg  = sgn && word[WordW-1];
    mag  = neg ? (~word + 1'b1) : word;
    ndig = 0;
    do begin
      digits[ndig] = 4'(mag % 10);
      mag          = mag / 10;
      ndig++;
    end while (mag != 0 && ndig < NumDig);
    total = ndig + (neg ? 1 : 0);
    if (neg) begin
      c.out_char = AsciiMinus;
      c.last     = 1'b0;
      c.length   = '0;
      pending_chars.push_back(c);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      c.out_char = AsciiZero + CharW'(digits[i]);
      c.last     = (i == 0);
      c.length   = c.last ? LenW'(total) : '0;
      pending_chars.push_back(c);
    end
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    logic [WordW-1:0] p10;
    int               e;
    case ($urandom_range(3))
      0: rand_word = $urandom;
      1: rand_word = $urandom_range(999);
      2: begin
        e   = $urandom_range(9);
        p10 = 1;
        for (int i = 0; i < e; i++) p10 = p10 * 10;
        rand_word = p10 + WordW'($urandom_range(2)) - 1;
      end
      default: rand_word = ~WordW'($urandom_range(1000)) + 1'b1;
    endcase
  endfunction

  task automatic send_item(input logic [WordW-1:0] word, input logic sgn, input string text);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= word;
    in_ch.is_signed <= sgn;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (text.len() != 0) push_text(text);
    else predict_text(word, sgn);
  endtask

  // Receiver: random stalls, plus one long hold-off once idling stops.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected item: out_char %0h last %0b length %0d",
               out_ch.out_char, out_ch.last, out_ch.length);
        errors++;
      end else begin
        want_char = pending_chars.pop_front();
        if (out_ch.out_char !== want_char.out_char) begin
          $error("out_char: expected %0h, got %0h", want_char.out_char, out_ch.out_char);
          errors++;
        end
        if (out_ch.last !== want_char.last) begin
          $error("last: expected %0b, got %0b", want_char.last, out_ch.last);
          errors++;
        end
        if (out_ch.length !== want_char.length) begin
          $error("length: expected %0d, got %0d", want_char.length, out_ch.length);
          errors++;
        end
      end
    end
  end

  initial begin
    #4ms;
    $display("int_to_decimal_ascii_top: mismatch");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.value     = '0;
    in_ch.is_signed = 1'b0;
    directed_rows = '{
      '{32'h0000_0000, 1'b0, "0"},
      '{32'h0000_0000, 1'b1, "0"},
      '{32'hFFFF_FFFF, 1'b0, "4294967295"},
      '{32'hFFFF_FFFF, 1'b1, "-1"},
      '{32'h8000_0000, 1'b1, "-2147483648"},
      '{32'h8000_0000, 1'b0, "2147483648"},
      '{32'h7FFF_FFFF, 1'b1, "2147483647"},
      '{32'h8000_0001, 1'b1, "-2147483647"},
      '{32'd9,         1'b0, "9"},
      '{32'd10,        1'b1, "10"},
      '{32'd1000000000, 1'b0, "1000000000"},
      '{32'd999999999, 1'b1, ""},
      '{32'hFFFF_FFF6, 1'b1, "-10"},
      '{32'h1234_5678, 1'b0, ""},
      '{32'hA5A5_A5A5, 1'b1, ""},
      '{32'h5A5A_5A5A, 1'b0, ""},
      '{32'hFFFF_FFF7, 1'b1, ""},
      '{32'd100,       1'b1, ""}
    };
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].value, directed_rows[i].is_signed, directed_rows[i].text);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) begin
        snd_idle_pct = 73;
        rcv_idle_pct = 25;
        idle_phase   = 1;
      end else if (n == 2 * NumRandom / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        idle_phase   = 2;
      end
      send_item(rand_word(), 1'($urandom_range(1)), "");
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("int_to_decimal_ascii_top: match");
    end else begin
      $display("int_to_decimal_ascii_top: mismatch");
    end
    $finish;
  end

endmodule
